[rtl/core/lcdseq_pkg.sv]
// Shared types, constants and microcode helpers for the character LCD sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none
package lcdseq_pkg;

    localparam int UaWidth = 5;

    typedef enum logic [1:0] {
        OP_WRITE_CHAR = 2'd0,
        OP_SET_CURSOR = 2'd1,
        OP_CLEAR      = 2'd2,
        OP_INIT       = 2'd3
    } t_op;

    typedef enum logic [2:0] {
        REG_ENABLE_HALF  = 3'd0,
        REG_POWERUP      = 3'd1,
        REG_GAP          = 3'd2,
        REG_SETTLE       = 3'd3,
        REG_LINE2_OFFSET = 3'd4,
        REG_FUNC_SET     = 3'd5,
        REG_DISP_CTRL    = 3'd6,
        REG_ENTRY_MODE   = 3'd7
    } t_reg_idx;

    // nibble source
    typedef enum logic [2:0] {
        NS_ZERO  = 3'd0,
        NS_INIT3 = 3'd1,
        NS_INIT2 = 3'd2,
        NS_HI    = 3'd3,
        NS_LO    = 3'd4
    } t_nsel;

    // byte source
    typedef enum logic [2:0] {
        BS_LATCH = 3'd0,
        BS_FSET  = 3'd1,
        BS_DCTL  = 3'd2,
        BS_ENTRY = 3'd3,
        BS_CLEAR = 3'd4
    } t_bsel;

    // hold time source
    typedef enum logic [1:0] {
        HS_HALF        = 2'd0,
        HS_HALF_GAP    = 2'd1,
        HS_HALF_SETTLE = 2'd2,
        HS_POWERUP     = 2'd3
    } t_hsel;

    typedef struct packed {
        logic  last;
        logic  en;
        t_nsel nsel;
        t_bsel bsel;
        t_hsel hsel;
    } t_uword;

    typedef struct packed {
        logic [7:0] enable_half_ms;
        logic [7:0] powerup_ms;
        logic [7:0] gap_ms;
        logic [7:0] settle_ms;
        logic [6:0] line_two_offset;
        logic [7:0] function_set_word;
        logic [7:0] display_control_word;
        logic [7:0] entry_mode_word;
    } t_cfg;

    typedef struct packed {
        logic       reg_select;
        logic [3:0] bus_nibble;
        logic       enable_level;
        logic [9:0] hold_ms;
        logic       last;
    } t_step;

    // program entry points
    localparam logic [UaWidth-1:0] UA_INIT  = 5'd0;
    localparam logic [UaWidth-1:0] UA_CLEAR = 5'd21;
    localparam logic [UaWidth-1:0] UA_BYTE  = 5'd25;
    localparam logic [UaWidth-1:0] UA_END   = 5'd28;

    localparam logic [7:0] CMD_CLEAR     = 8'h01;
    localparam logic [7:0] CMD_SET_DDRAM = 8'h80;
    localparam logic [3:0] NIB_INIT_8BIT = 4'h3;
    localparam logic [3:0] NIB_INIT_4BIT = 4'h2;

    function automatic t_uword uw(logic last, logic en, t_nsel nsel, t_bsel bsel,
                                  t_hsel hsel);
        t_uword w;
        w.last = last;
        w.en   = en;
        w.nsel = nsel;
        w.bsel = bsel;
        w.hsel = hsel;
        return w;
    endfunction

endpackage
`default_nettype wire

[rtl/core/lcdseq_cfg.sv]
// Configuration register file of the LCD sequencer.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_cfg
    import lcdseq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_index,
    input  wire  [7:0] i_cfg_wdata,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.enable_half_ms       <= 8'd10;
            r_cfg.powerup_ms           <= 8'd50;
            r_cfg.gap_ms               <= 8'd10;
            r_cfg.settle_ms            <= 8'd20;
            r_cfg.line_two_offset      <= 7'h40;
            r_cfg.function_set_word    <= 8'h28;
            r_cfg.display_control_word <= 8'h0C;
            r_cfg.entry_mode_word      <= 8'h06;
        end else if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_index))
                REG_ENABLE_HALF:  r_cfg.enable_half_ms       <= i_cfg_wdata;
                REG_POWERUP:      r_cfg.powerup_ms           <= i_cfg_wdata;
                REG_GAP:          r_cfg.gap_ms               <= i_cfg_wdata;
                REG_SETTLE:       r_cfg.settle_ms            <= i_cfg_wdata;
                REG_LINE2_OFFSET: r_cfg.line_two_offset      <= i_cfg_wdata[6:0];
                REG_FUNC_SET:     r_cfg.function_set_word    <= i_cfg_wdata;
                REG_DISP_CTRL:    r_cfg.display_control_word <= i_cfg_wdata;
                REG_ENTRY_MODE:   r_cfg.entry_mode_word      <= i_cfg_wdata;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule
`default_nettype wire

[rtl/core/lcdseq_urom.sv]
// Microcode ROM: one control word per bus step of each command program.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_urom
    import lcdseq_pkg::*;
(
    input  wire  [UaWidth-1:0] i_addr,
    output t_uword             o_uword
);

    always_comb begin
        unique case (i_addr)
            // init: power-up wait, 0x3 x3, 0x2
            5'd0:  o_uword = uw(1'b0, 1'b0, NS_ZERO,  BS_LATCH, HS_POWERUP);
            5'd1:  o_uword = uw(1'b0, 1'b1, NS_INIT3, BS_LATCH, HS_HALF);
            5'd2:  o_uword = uw(1'b0, 1'b0, NS_INIT3, BS_LATCH, HS_HALF_GAP);
            5'd3:  o_uword = uw(1'b0, 1'b1, NS_INIT3, BS_LATCH, HS_HALF);
            5'd4:  o_uword = uw(1'b0, 1'b0, NS_INIT3, BS_LATCH, HS_HALF_GAP);
            5'd5:  o_uword = uw(1'b0, 1'b1, NS_INIT3, BS_LATCH, HS_HALF);
            5'd6:  o_uword = uw(1'b0, 1'b0, NS_INIT3, BS_LATCH, HS_HALF_GAP);
            5'd7:  o_uword = uw(1'b0, 1'b1, NS_INIT2, BS_LATCH, HS_HALF);
            5'd8:  o_uword = uw(1'b0, 1'b0, NS_INIT2, BS_LATCH, HS_HALF);
            // function set
            5'd9:  o_uword = uw(1'b0, 1'b1, NS_HI, BS_FSET, HS_HALF);
            5'd10: o_uword = uw(1'b0, 1'b0, NS_HI, BS_FSET, HS_HALF);
            5'd11: o_uword = uw(1'b0, 1'b1, NS_LO, BS_FSET, HS_HALF);
            5'd12: o_uword = uw(1'b0, 1'b0, NS_LO, BS_FSET, HS_HALF);
            // display control
            5'd13: o_uword = uw(1'b0, 1'b1, NS_HI, BS_DCTL, HS_HALF);
            5'd14: o_uword = uw(1'b0, 1'b0, NS_HI, BS_DCTL, HS_HALF);
            5'd15: o_uword = uw(1'b0, 1'b1, NS_LO, BS_DCTL, HS_HALF);
            5'd16: o_uword = uw(1'b0, 1'b0, NS_LO, BS_DCTL, HS_HALF);
            // entry mode, then settle
            5'd17: o_uword = uw(1'b0, 1'b1, NS_HI, BS_ENTRY, HS_HALF);
            5'd18: o_uword = uw(1'b0, 1'b0, NS_HI, BS_ENTRY, HS_HALF);
            5'd19: o_uword = uw(1'b0, 1'b1, NS_LO, BS_ENTRY, HS_HALF);
            5'd20: o_uword = uw(1'b0, 1'b0, NS_LO, BS_ENTRY, HS_HALF_SETTLE);
            // clear: tail of init, also entered directly
            5'd21: o_uword = uw(1'b0, 1'b1, NS_HI, BS_CLEAR, HS_HALF);
            5'd22: o_uword = uw(1'b0, 1'b0, NS_HI, BS_CLEAR, HS_HALF);
            5'd23: o_uword = uw(1'b0, 1'b1, NS_LO, BS_CLEAR, HS_HALF);
            5'd24: o_uword = uw(1'b1, 1'b0, NS_LO, BS_CLEAR, HS_HALF_GAP);
            // latched byte: write char / set cursor
            5'd25: o_uword = uw(1'b0, 1'b1, NS_HI, BS_LATCH, HS_HALF);
            5'd26: o_uword = uw(1'b0, 1'b0, NS_HI, BS_LATCH, HS_HALF);
            5'd27: o_uword = uw(1'b0, 1'b1, NS_LO, BS_LATCH, HS_HALF);
            5'd28: o_uword = uw(1'b1, 1'b0, NS_LO, BS_LATCH, HS_HALF);
            default: o_uword = uw(1'b1, 1'b0, NS_ZERO, BS_LATCH, HS_HALF);
        endcase
    end

endmodule
`default_nettype wire

[rtl/core/lcdseq_dp.sv]
// Step datapath: turns a control word, the latched byte and the config into pin levels.
// Depends on lcdseq_pkg.
`default_nettype none
module lcdseq_dp
    import lcdseq_pkg::*;
(
    input  wire t_uword i_uword,
    input  wire t_cfg   i_cfg,
    input  wire  [7:0]  i_byte,
    input  wire         i_rs,
    output t_step       o_step
);

    logic [7:0] w_byte;
    logic [3:0] w_nib;
    logic [7:0] w_extra;
    logic [7:0] w_base;

    always_comb begin
        unique case (i_uword.bsel)
            BS_FSET:  w_byte = i_cfg.function_set_word;
            BS_DCTL:  w_byte = i_cfg.display_control_word;
            BS_ENTRY: w_byte = i_cfg.entry_mode_word;
            BS_CLEAR: w_byte = CMD_CLEAR;
            default:  w_byte = i_byte;
        endcase

        unique case (i_uword.nsel)
            NS_INIT3: w_nib = NIB_INIT_8BIT;
            NS_INIT2: w_nib = NIB_INIT_4BIT;
            NS_HI:    w_nib = w_byte[7:4];
            NS_LO:    w_nib = w_byte[3:0];
            default:  w_nib = 4'h0;
        endcase

        w_base = i_cfg.enable_half_ms;
        unique case (i_uword.hsel)
            HS_HALF_GAP:    w_extra = i_cfg.gap_ms;
            HS_HALF_SETTLE: w_extra = i_cfg.settle_ms;
            HS_POWERUP: begin
                w_base  = i_cfg.powerup_ms;
                w_extra = 8'd0;
            end
            default:        w_extra = 8'd0;
        endcase

        o_step.reg_select   = i_rs;
        o_step.bus_nibble   = w_nib;
        o_step.enable_level = i_uword.en;
        o_step.hold_ms      = {2'b00, w_base} + {2'b00, w_extra};
        o_step.last         = i_uword.last;
    end

endmodule
`default_nettype wire

[rtl/core/char_lcd_4bit_command_sequencer_unit.sv]
// Character LCD 4-bit command sequencer, top level.
// Microcoded: step counter over lcdseq_urom, datapath lcdseq_dp, registers lcdseq_cfg.
//
// Use: one command beat on the input channel (i_in_valid / o_in_stall) with
// i_opcode: write char, set cursor, clear or init. The block answers with a
// run of pin-state beats on the output channel (o_out_valid / i_out_stall):
// RS, D4..D7 nibble, enable level and hold time in ms; o_last marks the final
// beat of the run. A downstream timer applies the hold times.
// Write char, set cursor and clear give 4 beats, init gives 25.
// The command is latched into the step counter and byte register; each step's beat
// is then registered in the output register, one beat per cycle while the receiver
// does not stall, as the step counter advances once per cycle. The next command
// is taken the cycle after the last beat is loaded into the output register.
// Receiver stall freezes the step counter and holds the output beat.
// Config writes (i_cfg_we) are taken any cycle, intended while idle.
// Reset: idle, no output beat, config registers at their defaults.
`default_nettype none
module char_lcd_4bit_command_sequencer_unit
    import lcdseq_pkg::*;
(
    input  wire        i_clk,
    input  wire        i_rst_n,
    input  wire        i_cfg_we,
    input  wire  [2:0] i_cfg_index,
    input  wire  [7:0] i_cfg_wdata,
    input  wire        i_in_valid,
    output logic       o_in_stall,
    input  wire  [1:0] i_opcode,
    input  wire  [7:0] i_char_code,
    input  wire  [5:0] i_column,
    input  wire        i_line_select,
    output logic       o_out_valid,
    input  wire        i_out_stall,
    output logic       o_reg_select,
    output logic [3:0] o_bus_nibble,
    output logic       o_enable_level,
    output logic [9:0] o_hold_ms,
    output logic       o_last
);

    t_cfg               w_cfg;
    t_uword             w_uword;
    t_step              w_step;
    logic               r_busy;
    logic [UaWidth-1:0] r_pc;
    logic [7:0]         r_byte;
    logic               r_rs;
    logic               r_out_valid;
    t_step              r_out;
    logic               w_accept;
    logic               w_adv;
    logic [7:0]         w_addr;

    lcdseq_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (w_cfg)
    );

    lcdseq_urom u_urom (
        .i_addr  (r_pc),
        .o_uword (w_uword)
    );

    lcdseq_dp u_dp (
        .i_uword (w_uword),
        .i_cfg   (w_cfg),
        .i_byte  (r_byte),
        .i_rs    (r_rs),
        .o_step  (w_step)
    );

    assign o_in_stall = r_busy;
    assign w_accept   = i_in_valid && !r_busy;
    assign w_adv      = r_busy && (!r_out_valid || !i_out_stall);
    assign w_addr     = ({1'b0, i_line_select ? w_cfg.line_two_offset : 7'd0})
                      + {2'b00, i_column};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy      <= 1'b0;
            r_pc        <= UA_INIT;
            r_rs        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_busy <= 1'b1;
                r_rs   <= (t_op'(i_opcode) == OP_WRITE_CHAR);
                unique case (t_op'(i_opcode))
                    OP_WRITE_CHAR: begin
                        r_pc   <= UA_BYTE;
                        r_byte <= i_char_code;
                    end
                    OP_SET_CURSOR: begin
                        r_pc   <= UA_BYTE;
                        r_byte <= CMD_SET_DDRAM | w_addr;
                    end
                    OP_CLEAR: r_pc <= UA_CLEAR;
                    OP_INIT:  r_pc <= UA_INIT;
                endcase
            end else if (w_adv) begin
                r_pc <= r_pc + UaWidth'(1);
                if (w_uword.last) begin
                    r_busy <= 1'b0;
                end
            end

            if (w_adv) begin
                r_out_valid <= 1'b1;
                r_out       <= w_step;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid    = r_out_valid;
    assign o_reg_select   = r_out.reg_select;
    assign o_bus_nibble   = r_out.bus_nibble;
    assign o_enable_level = r_out.enable_level;
    assign o_hold_ms      = r_out.hold_ms;
    assign o_last         = r_out.last;

    a_last_ends_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_adv && w_uword.last) |=> !r_busy)
        else $error("sequencer still busy after last step");

    a_pc_in_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_busy |-> (r_pc <= UA_END))
        else $error("step counter ran past the program");

    a_strobe_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_enable_level) |-> !o_last)
        else $error("run ended with enable high");

    a_no_accept_pending: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall && !o_last && !r_busy) |-> 1'b0)
        else $error("run lost its sequencer before the last beat");

endmodule
`default_nettype wire

[tb/tb_char_lcd_4bit_command_sequencer_unit.sv]
`timescale 1ns / 1ps
// Self-checking testbench for char_lcd_4bit_command_sequencer_unit.
// Predicts the LCD pin-state beats of every command in a scoreboard class and
// compares them as they come out. Depends on lcdseq_pkg and the RTL only.
module tb_char_lcd_4bit_command_sequencer_unit;
    import lcdseq_pkg::*;

    localparam int CycleLimit = 400000;

    class lcd_step_scoreboard;
        t_cfg  cfg;
        bit    rs_level;
        t_step expected_steps[$];
        int    mismatch_count;
        int    beats_checked;
        int    op_count[4];

        function new();
            cfg.enable_half_ms       = 8'd10;
            cfg.powerup_ms           = 8'd50;
            cfg.gap_ms               = 8'd10;
            cfg.settle_ms            = 8'd20;
            cfg.line_two_offset      = 7'h40;
            cfg.function_set_word    = 8'h28;
            cfg.display_control_word = 8'h0C;
            cfg.entry_mode_word      = 8'h06;
            rs_level                 = 1'b0;
        endfunction

        function void write_reg(t_reg_idx idx, logic [7:0] value);
            case (idx)
                REG_ENABLE_HALF:  cfg.enable_half_ms       = value;
                REG_POWERUP:      cfg.powerup_ms           = value;
                REG_GAP:          cfg.gap_ms               = value;
                REG_SETTLE:       cfg.settle_ms            = value;
                REG_LINE2_OFFSET: cfg.line_two_offset      = value[6:0];
                REG_FUNC_SET:     cfg.function_set_word    = value;
                REG_DISP_CTRL:    cfg.display_control_word = value;
                REG_ENTRY_MODE:   cfg.entry_mode_word      = value;
                default: ;
            endcase
        endfunction

        function void push_step(logic rs, logic [3:0] nib, logic en, logic [9:0] hold);
            t_step s;
            s.reg_select   = rs;
            s.bus_nibble   = nib;
            s.enable_level = en;
            s.hold_ms      = hold;
            s.last         = 1'b0;
            expected_steps.push_back(s);
        endfunction

        // enable-high step, then enable-low step carrying any extra wait
        function void push_nibble(logic rs, logic [3:0] nib, logic [7:0] extra);
            push_step(rs, nib, 1'b1, {2'b00, cfg.enable_half_ms});
            push_step(rs, nib, 1'b0, {2'b00, cfg.enable_half_ms} + {2'b00, extra});
        endfunction

        function void push_byte(logic rs, logic [7:0] value, logic [7:0] extra);
            push_nibble(rs, value[7:4], 8'd0);
            push_nibble(rs, value[3:0], extra);
        endfunction

        function void predict_pin_steps(t_op op, logic [7:0] ch, logic [5:0] col,
                                        logic line);
            logic [7:0] addr;
            t_step      tail;
            op_count[int'(op)]++;
            case (op)
                OP_WRITE_CHAR: begin
                    rs_level = 1'b1;
                    push_byte(1'b1, ch, 8'd0);
                end
                OP_SET_CURSOR: begin
                    rs_level = 1'b0;
                    addr = (line ? {1'b0, cfg.line_two_offset} : 8'd0) + {2'b00, col};
                    push_byte(1'b0, CMD_SET_DDRAM | addr, 8'd0);
                end
                OP_CLEAR: begin
                    rs_level = 1'b0;
                    push_byte(1'b0, CMD_CLEAR, cfg.gap_ms);
                end
                default: begin
                    // RS forced low for the whole init run
                    rs_level = 1'b0;
                    push_step(1'b0, 4'h0, 1'b0, {2'b00, cfg.powerup_ms});
                    repeat (3) push_nibble(1'b0, NIB_INIT_8BIT, cfg.gap_ms);
                    push_nibble(1'b0, NIB_INIT_4BIT, 8'd0);
                    push_byte(1'b0, cfg.function_set_word, 8'd0);
                    push_byte(1'b0, cfg.display_control_word, 8'd0);
                    push_byte(1'b0, cfg.entry_mode_word, cfg.settle_ms);
                    push_byte(1'b0, CMD_CLEAR, cfg.gap_ms);
                end
            endcase
            tail      = expected_steps.pop_back();
            tail.last = 1'b1;
            expected_steps.push_back(tail);
        endfunction

        task report(string msg);
            if (mismatch_count < 100)
                $display("MISMATCH @%0t: %s", $realtime, msg);
            mismatch_count++;
        endtask

        task check_pin_step(t_step got);
            t_step want;
            beats_checked++;
            if (expected_steps.size() == 0) begin
                report($sformatf("beat %0d unexpected: rs=%0d nib=%h en=%0d hold=%0d last=%0d",
                                 beats_checked, got.reg_select, got.bus_nibble,
                                 got.enable_level, got.hold_ms, got.last));
                return;
            end
            want = expected_steps.pop_front();
            if (got.reg_select !== want.reg_select)
                report($sformatf("beat %0d reg_select got %0d want %0d", beats_checked,
                                 got.reg_select, want.reg_select));
            if (got.bus_nibble !== want.bus_nibble)
                report($sformatf("beat %0d bus_nibble got %h want %h", beats_checked,
                                 got.bus_nibble, want.bus_nibble));
            if (got.enable_level !== want.enable_level)
                report($sformatf("beat %0d enable_level got %0d want %0d", beats_checked,
                                 got.enable_level, want.enable_level));
            if (got.hold_ms !== want.hold_ms)
                report($sformatf("beat %0d hold_ms got %0d want %0d", beats_checked,
                                 got.hold_ms, want.hold_ms));
            if (got.last !== want.last)
                report($sformatf("beat %0d last got %0d want %0d", beats_checked,
                                 got.last, want.last));
        endtask
    endclass

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_we      = 1'b0;
    logic [2:0] i_cfg_index   = '0;
    logic [7:0] i_cfg_wdata   = '0;
    logic       i_in_valid    = 1'b0;
    logic [1:0] i_opcode      = '0;
    logic [7:0] i_char_code   = '0;
    logic [5:0] i_column      = '0;
    logic       i_line_select = 1'b0;
    logic       i_out_stall   = 1'b0;
    logic       o_in_stall;
    logic       o_out_valid;
    logic       o_reg_select;
    logic [3:0] o_bus_nibble;
    logic       o_enable_level;
    logic [9:0] o_hold_ms;
    logic       o_last;

    t_step seen_step;
    assign seen_step = {o_reg_select, o_bus_nibble, o_enable_level, o_hold_ms, o_last};

    lcd_step_scoreboard sb = new();

    bit sender_idle_en   = 1'b1;
    bit receiver_idle_en = 1'b1;
    int stall_left       = 0;
    int cycle_count      = 0;
    int random_sets      = 0;

    char_lcd_4bit_command_sequencer_unit dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_wdata   (i_cfg_wdata),
        .i_in_valid    (i_in_valid),
        .o_in_stall    (o_in_stall),
        .i_opcode      (i_opcode),
        .i_char_code   (i_char_code),
        .i_column      (i_column),
        .i_line_select (i_line_select),
        .o_out_valid   (o_out_valid),
        .i_out_stall   (i_out_stall),
        .o_reg_select  (o_reg_select),
        .o_bus_nibble  (o_bus_nibble),
        .o_enable_level(o_enable_level),
        .o_hold_ms     (o_hold_ms),
        .o_last        (o_last)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("char_lcd_4bit_command_sequencer_unit verification failed");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pin_step(seen_step);
    end

    // receiver stall bursts of random length
    always @(negedge i_clk) begin
        if (!receiver_idle_en) begin
            i_out_stall <= 1'b0;
        end else if (stall_left > 0) begin
            stall_left--;
            i_out_stall <= 1'b1;
        end else if ($urandom_range(0, 4) == 0) begin
            stall_left = $urandom_range(0, 6);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    task automatic send_command(t_op op, logic [7:0] ch, logic [5:0] col, logic line);
        int gap;
        @(negedge i_clk);
        if (sender_idle_en && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 7);
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid    <= 1'b1;
        i_opcode      <= op;
        i_char_code   <= ch;
        i_column      <= col;
        i_line_select <= line;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.predict_pin_steps(op, ch, col, line);
    endtask

    task automatic send_random_command();
        int  pick;
        t_op op;
        pick = $urandom_range(0, 99);
        if (pick < 50)      op = OP_WRITE_CHAR;
        else if (pick < 72) op = OP_SET_CURSOR;
        else if (pick < 86) op = OP_CLEAR;
        else                op = OP_INIT;
        send_command(op, 8'($urandom_range(0, 255)), 6'($urandom_range(0, 63)),
                     1'($urandom_range(0, 1)));
    endtask

    task automatic wait_for_drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (sb.expected_steps.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic load_settings(bit use_random, logic [7:0] fill);
        logic [7:0] value;
        for (int i = 0; i < 8; i++) begin
            value = use_random ? 8'($urandom_range(0, 255)) : fill;
            @(negedge i_clk);
            i_cfg_we    <= 1'b1;
            i_cfg_index <= i[2:0];
            i_cfg_wdata <= value;
            @(posedge i_clk);
            sb.write_reg(t_reg_idx'(i), value);
        end
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    initial begin
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // reset defaults
        send_command(OP_INIT, 8'h00, 6'd0, 1'b0);
        send_command(OP_WRITE_CHAR, 8'h00, 6'd0, 1'b0);
        send_command(OP_WRITE_CHAR, 8'hFF, 6'd63, 1'b1);
        send_command(OP_INIT, 8'hFF, 6'd63, 1'b1);
        send_command(OP_SET_CURSOR, 8'h00, 6'd0, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 6'd63, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 6'd0, 1'b1);
        send_command(OP_SET_CURSOR, 8'hFF, 6'd63, 1'b1);
        send_command(OP_CLEAR, 8'hA5, 6'd21, 1'b1);
        send_command(OP_WRITE_CHAR, 8'h5A, 6'd42, 1'b0);

        // all registers at zero
        wait_for_drain();
        load_settings(1'b0, 8'h00);
        send_command(OP_INIT, 8'h00, 6'd0, 1'b0);
        send_command(OP_CLEAR, 8'h00, 6'd0, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 6'd63, 1'b1);
        send_command(OP_WRITE_CHAR, 8'hC3, 6'd0, 1'b0);

        // all registers at max, line offset top bit masked
        wait_for_drain();
        load_settings(1'b0, 8'hFF);
        send_command(OP_WRITE_CHAR, 8'h3C, 6'd0, 1'b0);
        send_command(OP_INIT, 8'h00, 6'd0, 1'b0);
        send_command(OP_CLEAR, 8'h00, 6'd0, 1'b0);
        send_command(OP_SET_CURSOR, 8'h00, 6'd63, 1'b1);
        send_command(OP_SET_CURSOR, 8'h00, 6'd0, 1'b1);

        for (int phase = 0; phase < 7; phase++) begin
            wait_for_drain();
            load_settings(1'b1, 8'h00);
            random_sets++;
            sender_idle_en   = (phase != 6) && ($urandom_range(0, 3) != 0);
            receiver_idle_en = (phase != 6) && ($urandom_range(0, 3) != 0);
            repeat (60) send_random_command();
        end

        wait_for_drain();
        if (sb.expected_steps.size() != 0)
            sb.report($sformatf("%0d expected beats never arrived", sb.expected_steps.size()));

        $display("Ran %0d commands: %0d char, %0d cursor, %0d clear, %0d init; %0d beats checked",
                 sb.op_count[0] + sb.op_count[1] + sb.op_count[2] + sb.op_count[3],
                 sb.op_count[0], sb.op_count[1], sb.op_count[2], sb.op_count[3],
                 sb.beats_checked);
        $display("Register sets: reset defaults, all zero, all ones, %0d random; %0d mismatches",
                 random_sets, sb.mismatch_count);
        if (sb.mismatch_count == 0) begin
            $display("char_lcd_4bit_command_sequencer_unit verification clean");
        end else begin
            $display("char_lcd_4bit_command_sequencer_unit verification failed");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/core/lcdseq_pkg.sv
rtl/core/lcdseq_cfg.sv
rtl/core/lcdseq_urom.sv
rtl/core/lcdseq_dp.sv
rtl/core/char_lcd_4bit_command_sequencer_unit.sv
tb/tb_char_lcd_4bit_command_sequencer_unit.sv
